FILE: hdl/itr_pkg.sv
// Shared types, constants and helper functions for the integer-to-text block.
// Used by the divider, the output sequencer and the top level; depends on nothing else.
package itr_pkg;

	localparam int VALUE_W     = 64;
	localparam int NARROW_W    = 32;
	localparam int DIGITS_MAX  = 64;
	localparam int DIGIT_W     = 4;
	localparam int RADIX_W     = 5;
	localparam int CHAR_W      = 7;
	localparam int ADDR_W      = $clog2(DIGITS_MAX);
	localparam int COUNT_W     = ADDR_W + 1;
	localparam int BITCNT_W    = $clog2(VALUE_W);

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	// Register index decoded from paddr[2].
	localparam logic REG_RADIX = 1'b0;

	localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A      = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_ERROR  = 7'h00;

	localparam logic [VALUE_W-1:0] MOST_NEG_WIDE = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic load;
		logic step;
		logic first;
	} div_ctl_t;

	typedef struct packed {
		logic               start;
		logic               err;
		logic               neg;
		logic [COUNT_W-1:0] count;
	} out_cmd_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < 4'd10) begin
			res = CHAR_ZERO + {3'b000, d};
		end else begin
			res = CHAR_A + {3'b000, d} - 7'd10;
		end
		return res;
	endfunction

endpackage

FILE: hdl/itr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the digits of one number; depends on nothing else.
module itr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/itr_div.sv
// Bit-serial divider by the radix: one quotient bit per cycle while ctl.step is set, remainder is the digit.
// Depends on itr_pkg.
module itr_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  itr_pkg::div_ctl_t                  ctl,
	input  logic [itr_pkg::VALUE_W-1:0]        mag,
	input  logic                               wide,
	input  logic [itr_pkg::RADIX_W-1:0]        radix,
	output logic [itr_pkg::DIGIT_W-1:0]        digit,
	output logic                               quot_nz
);

	logic [itr_pkg::VALUE_W-1:0] quot_q;
	logic [itr_pkg::DIGIT_W-1:0] rem_q;
	logic                        qnz_q;

	logic [itr_pkg::DIGIT_W-1:0] rem_in;
	logic                        msb;
	logic [itr_pkg::RADIX_W-1:0] trial;
	logic                        qbit;
	logic [itr_pkg::RADIX_W-1:0] diff;
	logic [itr_pkg::VALUE_W-1:0] quot_nxt;

	always_comb begin
		rem_in = ctl.first ? '0 : rem_q;
		msb    = wide ? quot_q[itr_pkg::VALUE_W-1] : quot_q[itr_pkg::NARROW_W-1];
		trial  = {rem_in, msb};
		qbit   = (trial >= radix);
		diff   = trial - radix;
		digit  = qbit ? diff[itr_pkg::DIGIT_W-1:0] : trial[itr_pkg::DIGIT_W-1:0];
		quot_nz = (ctl.first ? 1'b0 : qnz_q) | qbit;
		// In 32-bit mode the upper half is kept clear so the quotient stays narrow.
		if (wide) begin
			quot_nxt = {quot_q[itr_pkg::VALUE_W-2:0], qbit};
		end else begin
			quot_nxt = {{(itr_pkg::VALUE_W-itr_pkg::NARROW_W){1'b0}},
				quot_q[itr_pkg::NARROW_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			qnz_q <= 1'b0;
		end else if (ctl.step) begin
			rem_q <= digit;
			qnz_q <= quot_nz;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quot_q <= mag;
		end else if (ctl.step) begin
			quot_q <= quot_nxt;
		end
	end

endmodule

FILE: hdl/itr_out.sv
// Output sequencer: reads stored digits back most significant first and drives the
// result stream through an output register. Depends on itr_pkg.
module itr_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  itr_pkg::out_cmd_t                  cmd,
	output logic                               rd_en,
	output logic [itr_pkg::ADDR_W-1:0]         rd_addr,
	input  logic [itr_pkg::DIGIT_W-1:0]        rd_data,
	output logic                               busy,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,  // [6:0] character, [7] zero
	output logic                               m_tlast,
	output logic                               m_tuser   // [0] error
);

	logic                          err_pend_q;
	logic                          sign_pend_q;
	logic [itr_pkg::COUNT_W-1:0]   rd_cnt_q;
	logic                          rd_pend_q;
	logic                          rd_last_q;
	logic                          out_valid_q;
	logic [itr_pkg::CHAR_W-1:0]    out_char_q;
	logic                          out_last_q;
	logic                          out_err_q;

	logic                          can_load;
	logic                          load_err;
	logic                          load_sign;
	logic                          load_dig;
	logic [itr_pkg::COUNT_W-1:0]   rd_idx;

	always_comb begin
		can_load  = !out_valid_q || m_tready;
		load_err  = err_pend_q && can_load;
		load_sign = !err_pend_q && sign_pend_q && can_load;
		load_dig  = !err_pend_q && !sign_pend_q && rd_pend_q && can_load;
		// The RAM read data holds when no read is issued, so a stalled digit waits there.
		rd_en     = (rd_cnt_q != '0) && (!rd_pend_q || load_dig);
		rd_idx    = rd_cnt_q - 1'b1;
		rd_addr   = rd_idx[itr_pkg::ADDR_W-1:0];
		busy      = err_pend_q || sign_pend_q || (rd_cnt_q != '0) || rd_pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_pend_q  <= 1'b0;
			sign_pend_q <= 1'b0;
			rd_cnt_q    <= '0;
			rd_pend_q   <= 1'b0;
			rd_last_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				err_pend_q  <= cmd.err;
				sign_pend_q <= cmd.neg;
				rd_cnt_q    <= cmd.err ? '0 : cmd.count;
			end else begin
				if (load_err) begin
					err_pend_q <= 1'b0;
				end
				if (load_sign) begin
					sign_pend_q <= 1'b0;
				end
				if (rd_en) begin
					rd_cnt_q <= rd_idx;
				end
			end
			if (rd_en) begin
				rd_pend_q <= 1'b1;
				rd_last_q <= (rd_cnt_q == itr_pkg::COUNT_W'(1));
			end else if (load_dig) begin
				rd_pend_q <= 1'b0;
			end

			if (load_err) begin
				out_valid_q <= 1'b1;
				out_char_q  <= itr_pkg::CHAR_ERROR;
				out_last_q  <= 1'b1;
				out_err_q   <= 1'b1;
			end else if (load_sign) begin
				out_valid_q <= 1'b1;
				out_char_q  <= itr_pkg::CHAR_MINUS;
				out_last_q  <= 1'b0;
				out_err_q   <= 1'b0;
			end else if (load_dig) begin
				out_valid_q <= 1'b1;
				out_char_q  <= itr_pkg::digit_char(rd_data);
				out_last_q  <= rd_last_q;
				out_err_q   <= 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

FILE: hdl/integer_to_radix_text.sv
// A W-bit operand (W = 32 or 64) with D digits is divided serially by the single-bit
// remainder/quotient loop of the divider, one digit after another; the digits are then
// read back from the RAM into the output register, and the minus sign leaves sooner.
// Items are taken only in idle; characters leave one per cycle while m_tready is high.
// Reset clears control state and sets radix to 10; the digit RAM is not cleared.
module integer_to_radix_text (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value_bits
	input  logic [1:0]  s_tuser,   // [0] is_signed, [1] is_wide
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
	output logic        m_tlast,   // last
	output logic        m_tuser,   // [0] error
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                          state_q;
	logic [itr_pkg::RADIX_W-1:0]     radix_q;
	logic [itr_pkg::BITCNT_W-1:0]    bit_cnt_q;
	logic                            first_q;
	logic                            wide_q;
	logic                            neg_q;
	logic [itr_pkg::COUNT_W-1:0]     n_q;

	logic                            accept;
	logic                            in_signed;
	logic                            in_wide;
	logic                            in_neg;
	logic                            in_err;
	logic [itr_pkg::NARROW_W-1:0]    low;
	logic [itr_pkg::NARROW_W-1:0]    low_mag;
	logic [itr_pkg::VALUE_W-1:0]     mag;
	logic [itr_pkg::BITCNT_W-1:0]    bit_top;
	logic                            digit_done;

	itr_pkg::div_ctl_t               div_ctl;
	itr_pkg::out_cmd_t               out_cmd;
	logic [itr_pkg::DIGIT_W-1:0]     digit;
	logic                            quot_nz;
	logic                            rd_en;
	logic [itr_pkg::ADDR_W-1:0]      rd_addr;
	logic [itr_pkg::DIGIT_W-1:0]     rd_data;
	logic                            out_busy;
	logic                            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == itr_pkg::REG_RADIX);
	assign prdata = (paddr[2] == itr_pkg::REG_RADIX) ? {27'b0, radix_q} : '0;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		in_signed = s_tuser[0];
		in_wide   = s_tuser[1];
		low       = s_tdata[itr_pkg::NARROW_W-1:0];
		low_mag   = low[itr_pkg::NARROW_W-1] ? (~low + 1'b1) : low;
		if (in_wide) begin
			in_neg = in_signed && s_tdata[itr_pkg::VALUE_W-1];
			mag    = in_neg ? (~s_tdata + 1'b1) : s_tdata;
		end else begin
			in_neg = in_signed && low[itr_pkg::NARROW_W-1];
			mag    = {{(itr_pkg::VALUE_W-itr_pkg::NARROW_W){1'b0}}, in_neg ? low_mag : low};
		end
		in_err  = in_signed && in_wide && (s_tdata == itr_pkg::MOST_NEG_WIDE);
		bit_top = in_wide ? itr_pkg::BITCNT_W'(itr_pkg::VALUE_W - 1)
			: itr_pkg::BITCNT_W'(itr_pkg::NARROW_W - 1);

		digit_done    = (state_q == ST_DIV) && (bit_cnt_q == '0);
		div_ctl.load  = accept && !in_err;
		div_ctl.step  = (state_q == ST_DIV);
		div_ctl.first = first_q;

		out_cmd.start = (accept && in_err) || (digit_done && !quot_nz);
		out_cmd.err   = (state_q == ST_IDLE);
		// The error transaction stands alone, so no sign is queued with it.
		out_cmd.neg   = neg_q && (state_q != ST_IDLE);
		out_cmd.count = n_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			radix_q   <= itr_pkg::RADIX_RESET;
			bit_cnt_q <= '0;
			first_q   <= 1'b0;
			wide_q    <= 1'b0;
			neg_q     <= 1'b0;
			n_q       <= '0;
		end else begin
			if (cfg_wr) begin
				radix_q <= pwdata[itr_pkg::RADIX_W-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wide_q    <= in_wide;
						neg_q     <= in_neg;
						bit_cnt_q <= bit_top;
						first_q   <= 1'b1;
						n_q       <= '0;
						state_q   <= in_err ? ST_OUT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_cnt_q == '0) begin
						// A digit is complete; stop once the quotient has reached zero.
						n_q       <= n_q + 1'b1;
						first_q   <= 1'b1;
						bit_cnt_q <= wide_q ? itr_pkg::BITCNT_W'(itr_pkg::VALUE_W - 1)
							: itr_pkg::BITCNT_W'(itr_pkg::NARROW_W - 1);
						if (!quot_nz) begin
							state_q <= ST_OUT;
						end
					end else begin
						first_q   <= 1'b0;
						bit_cnt_q <= bit_cnt_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (!out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	itr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.mag     (mag),
		.wide    (wide_q),
		.radix   (itr_pkg::eff_radix(radix_q)),
		.digit   (digit),
		.quot_nz (quot_nz)
	);

	itr_ram #(
		.WIDTH (itr_pkg::DIGIT_W),
		.DEPTH (itr_pkg::DIGITS_MAX)
	) u_ram (
		.clk   (clk),
		.we    (digit_done),
		.waddr (n_q[itr_pkg::ADDR_W-1:0]),
		.wdata (digit),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	itr_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (out_cmd),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.busy     (out_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: hdl/itr_chk.sv
// Port-level checker for the integer-to-text block, bound to the top level.
// Depends only on the top level's ports.
module itr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// An error transaction is always a lone final character with code zero.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
		else $error("error transaction is not a lone zero character");

	// Every other character is a digit, a lower-case letter up to f, or a minus sign.
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
		((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) ||
		((m_tdata >= 8'h61) && (m_tdata <= 8'h66)) ||
		(m_tdata == 8'h2d))
		else $error("character outside the digit set");

	// A minus sign never ends the text.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == 8'h2d) |-> !m_tlast)
		else $error("minus sign marked as last");

	// Items are taken one at a time: after an input transaction the input side closes.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in progress");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output changed");

endmodule

bind integer_to_radix_text itr_chk u_itr_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
